@@ hdl/ccdc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccdc_pkg
// Shared widths, register indexes and controller/datapath interface types
// for the column chain deletion counter.
// ----------------------------------------------------------------------------
package ccdc_pkg;

    localparam int SYMW    = 8;  // grid character width
    localparam int DIMW    = 8;  // row and column count registers
    localparam int LENW    = 8;  // chain length values
    localparam int DELW    = 7;  // result width
    localparam int CFG_AW  = 2;  // configuration index width

    localparam logic [CFG_AW-1:0] REG_NUM_ROWS = 2'd0;
    localparam logic [CFG_AW-1:0] REG_NUM_COLS = 2'd1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic grid_we;
        logic dp_start;
        logic col_init;
        logic j_next;
        logic row_start;
        logic row_next;
        logic take;
        logic col_store;
        logic i_next;
        logic emit;
    } ccdc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_symbol;
        logic j_eq_i;
        logic cand_gt;
        logic col_le;
        logic row_last;
        logic col_last;
    } ccdc_status_t;

endpackage

@@ hdl/column_chain_deletion_count.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// column_chain_deletion_count
// Fewest columns to delete from a character grid so that every row is sorted.
// ----------------------------------------------------------------------------
// Characters stream in row-major order, one beat per cycle, into a grid
// memory sized MAX_ROWS x MAX_COLS. The beat carrying the last character
// starts a quadratic chain search over the columns, during which no input
// is taken. For each column i the search checks every earlier column j
// and, when column j could lengthen the chain, compares the two columns
// row by row (a registered read of the grid memories, then the compare),
// stopping at the first row out of order. The result sits in an output
// register, so loading of the next grid starts as soon as the search is
// done, even while that result still waits; only when an earlier result
// has not been taken yet does the block hold the new one back, with its
// input stalled, until the output frees up. Writing num_rows or num_cols
// restarts the load.
// ----------------------------------------------------------------------------
module column_chain_deletion_count
    import ccdc_pkg::*;
#(
    parameter int MAX_ROWS = 128,
    parameter int MAX_COLS = 128
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [DIMW-1:0]   cfg_data,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] symbol
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata    // [6:0] deletions, [7] zero
);

    ccdc_cmd_t       cmd;
    ccdc_status_t    status;
    logic [DELW-1:0] deletions;

    ccdc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .status   (status),
        .cmd      (cmd)
    );

    ccdc_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .symbol    (s_tdata[SYMW-1:0]),
        .cmd       (cmd),
        .status    (status),
        .deletions (deletions)
    );

    assign m_tdata = {1'b0, deletions};

    // A grid write happens only on an accepted beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.grid_we |-> (s_tvalid && s_tready))
        else $error("grid written without an accepted input beat");

    // A new result never overwrites one that has not been taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !(m_tvalid && !m_tready))
        else $error("pending result overwritten");

    // Row scanning only happens while input is held off.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.row_next || cmd.row_start) |-> !s_tready)
        else $error("row scan while accepting input");

    // Once a result is emitted, it appears on the output in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> m_tvalid)
        else $error("emitted result not presented");

endmodule

@@ hdl/ccdc_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccdc_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module ccdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/ccdc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccdc_ctrl
// Sequencer for grid loading and the column chain search, plus the result
// valid flag.
// ----------------------------------------------------------------------------
module ccdc_ctrl
    import ccdc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic         m_tready,
    output logic         m_tvalid,
    input  ccdc_status_t status,
    output ccdc_cmd_t    cmd
);

    localparam logic [2:0] S_LOAD   = 3'd0;
    localparam logic [2:0] S_INIT   = 3'd1;
    localparam logic [2:0] S_JREAD  = 3'd2;
    localparam logic [2:0] S_JCHK   = 3'd3;
    localparam logic [2:0] S_RISSUE = 3'd4;
    localparam logic [2:0] S_RCMP   = 3'd5;
    localparam logic [2:0] S_STORE  = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign s_tready = (state_reg == S_LOAD);
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_LOAD:
            begin
                cmd.grid_we = s_tvalid;
                if (s_tvalid && status.last_symbol)
                begin
                    cmd.dp_start = 1'b1;
                    state_next   = S_INIT;
                end
            end
            S_INIT:
            begin
                cmd.col_init = 1'b1;
                state_next   = S_JREAD;
            end
            S_JREAD:
            begin
                // The chain RAM read of column j lands during S_JCHK.
                state_next = status.j_eq_i ? S_STORE : S_JCHK;
            end
            S_JCHK:
            begin
                if (status.cand_gt)
                begin
                    cmd.row_start = 1'b1;
                    state_next    = S_RISSUE;
                end
                else
                begin
                    cmd.j_next = 1'b1;
                    state_next = S_JREAD;
                end
            end
            S_RISSUE:
            begin
                state_next = S_RCMP;
            end
            S_RCMP:
            begin
                if (!status.col_le)
                begin
                    cmd.j_next = 1'b1;
                    state_next = S_JREAD;
                end
                else if (status.row_last)
                begin
                    cmd.take   = 1'b1;
                    cmd.j_next = 1'b1;
                    state_next = S_JREAD;
                end
                else
                begin
                    cmd.row_next = 1'b1;
                    state_next   = S_RISSUE;
                end
            end
            S_STORE:
            begin
                cmd.col_store = 1'b1;
                if (status.col_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.i_next = 1'b1;
                    state_next = S_INIT;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ hdl/ccdc_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccdc_dp
// Datapath: dimension registers, grid and chain memories, loop counters,
// column compare and the result register.
// ----------------------------------------------------------------------------
module ccdc_dp
    import ccdc_pkg::*;
#(
    parameter int MAX_ROWS = 128,
    parameter int MAX_COLS = 128
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [DIMW-1:0]   cfg_data,
    input  logic [SYMW-1:0]   symbol,
    input  ccdc_cmd_t         cmd,
    output ccdc_status_t      status,
    output logic [DELW-1:0]   deletions
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TW    = $clog2(DEPTH + 1);
    localparam int CIW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    logic [DIMW-1:0]   rows_reg;
    logic [DIMW-1:0]   cols_reg;
    logic [TW-1:0]     pos_reg;
    logic [CIW-1:0]    i_reg;
    logic [CIW-1:0]    j_reg;
    logic [RIW-1:0]    r_reg;
    logic [AW-1:0]     base_reg;
    logic [LENW-1:0]   cur_reg;
    logic [LENW-1:0]   best_reg;
    logic [DELW-1:0]   deletions_reg;

    logic [2*DIMW-1:0] total;
    logic [AW-1:0]     addr_j;
    logic [AW-1:0]     addr_i;
    logic [SYMW-1:0]   grid_qj;
    logic [SYMW-1:0]   grid_qi;
    logic [LENW-1:0]   chain_q;
    logic [LENW-1:0]   cand;
    logic [DIMW-1:0]   diff;

    function automatic logic [DIMW-1:0] clamp_dim(input logic [DIMW-1:0] v, input int maxv);
        if (v == '0)
        begin
            return DIMW'(1);
        end
        else if (int'(v) > maxv)
        begin
            return DIMW'(maxv);
        end
        return v;
    endfunction

    assign total  = rows_reg * cols_reg;
    assign addr_j = AW'(32'(base_reg) + 32'(j_reg));
    assign addr_i = AW'(32'(base_reg) + 32'(i_reg));
    assign cand   = chain_q + LENW'(1);
    assign diff   = cols_reg - best_reg;

    assign status.last_symbol = (32'(pos_reg) + 32'd1 >= 32'(total));
    assign status.j_eq_i      = (j_reg == i_reg);
    assign status.cand_gt     = (cand > cur_reg);
    assign status.col_le      = !(grid_qj > grid_qi);
    assign status.row_last    = (32'(r_reg) + 32'd1 == 32'(rows_reg));
    assign status.col_last    = (32'(i_reg) + 32'd1 == 32'(cols_reg));

    assign deletions = deletions_reg;

    // Two copies of the grid give both column reads of one row in a cycle.
    ccdc_ram #(.WIDTH(SYMW), .DEPTH(DEPTH)) u_grid_j (
        .clk   (clk),
        .we    (cmd.grid_we),
        .waddr (pos_reg[AW-1:0]),
        .wdata (symbol),
        .raddr (addr_j),
        .rdata (grid_qj)
    );

    ccdc_ram #(.WIDTH(SYMW), .DEPTH(DEPTH)) u_grid_i (
        .clk   (clk),
        .we    (cmd.grid_we),
        .waddr (pos_reg[AW-1:0]),
        .wdata (symbol),
        .raddr (addr_i),
        .rdata (grid_qi)
    );

    ccdc_ram #(.WIDTH(LENW), .DEPTH(MAX_COLS)) u_chain (
        .clk   (clk),
        .we    (cmd.col_store),
        .waddr (i_reg),
        .wdata (cur_reg),
        .raddr (j_reg),
        .rdata (chain_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg      <= DIMW'(1);
            cols_reg      <= DIMW'(1);
            pos_reg       <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            r_reg         <= '0;
            base_reg      <= '0;
            cur_reg       <= '0;
            best_reg      <= '0;
            deletions_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_NUM_ROWS:
                    begin
                        rows_reg <= clamp_dim(cfg_data, MAX_ROWS);
                        pos_reg  <= '0;
                    end
                    REG_NUM_COLS:
                    begin
                        cols_reg <= clamp_dim(cfg_data, MAX_COLS);
                        pos_reg  <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (cmd.grid_we)
            begin
                pos_reg <= status.last_symbol ? '0 : pos_reg + TW'(1);
            end

            if (cmd.dp_start)
            begin
                i_reg    <= '0;
                best_reg <= '0;
            end
            if (cmd.col_init)
            begin
                cur_reg <= LENW'(1);
                j_reg   <= '0;
            end
            if (cmd.j_next)
            begin
                j_reg <= j_reg + CIW'(1);
            end
            if (cmd.row_start)
            begin
                r_reg    <= '0;
                base_reg <= '0;
            end
            if (cmd.row_next)
            begin
                r_reg    <= r_reg + RIW'(1);
                base_reg <= AW'(32'(base_reg) + 32'(cols_reg));
            end
            if (cmd.take)
            begin
                cur_reg <= cand;
            end
            if (cmd.col_store && (cur_reg > best_reg))
            begin
                best_reg <= cur_reg;
            end
            if (cmd.i_next)
            begin
                i_reg <= i_reg + CIW'(1);
            end
            if (cmd.emit)
            begin
                deletions_reg <= diff[DELW-1:0];
            end
        end
    end

endmodule

@@ verif/column_chain_deletion_count_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// column_chain_deletion_count_tb
// Self-checking bench for the column chain deletion counter.
// ----------------------------------------------------------------------------
// Grids of byte characters are streamed in row-major order under a range of
// row and column counts, including out-of-range register values, restarted
// loads and writes to unused register indexes. A predictor inside the bench
// mirrors the grid and runs the chain search on every completed grid. Each
// deletions beat is checked against the oldest outstanding prediction. Both
// stream sides idle at random, and the output side holds off once for a long
// stretch so that the block backs up and stalls its input.
// ----------------------------------------------------------------------------
module column_chain_deletion_count_tb;
    import ccdc_pkg::*;

    localparam int MAX_ROWS       = 128;
    localparam int MAX_COLS       = 128;
    localparam int ITEM_TARGET    = 1650;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 50;
    localparam int SQUEEZE_CYCLES = 1500;
    localparam int N_DIRECTED     = 30;

    // Indexes past the register list; writes to them must change nothing.
    localparam logic [CFG_AW-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_AW-1:0] REG_SPARE_3 = 2'd3;

    typedef enum logic {ROW_CFG, ROW_SYM} stim_kind_t;
    typedef enum int {FILL_RANDOM, FILL_NARROW, FILL_RISING, FILL_FLAT, FILL_RAILS} fill_t;

    typedef struct packed {
        stim_kind_t        kind;
        logic [CFG_AW-1:0] addr;       // register index, unused for symbols
        logic [DIMW-1:0]   value;      // register value or symbol
        logic              pinned;     // deletions below is the known answer
        logic [DELW-1:0]   deletions;
    } stim_row_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic [CFG_AW-1:0] cfg_addr;
    logic [DIMW-1:0]   cfg_data;
    logic              s_tvalid;
    logic              s_tready;
    logic [7:0]        s_tdata;   // [7:0] symbol
    logic              m_tvalid;
    logic              m_tready;
    logic [7:0]        m_tdata;   // [6:0] deletions, [7] zero

    // Predictor state.
    logic [SYMW-1:0]   grid_img [MAX_ROWS*MAX_COLS];
    int unsigned       rows_now;
    int unsigned       cols_now;
    int unsigned       fill_pos;
    logic [DELW-1:0]   owed_deletions [$];

    int unsigned       items_sent = 0;
    int unsigned       mismatches = 0;
    bit                squeeze_req = 1'b0;

    stim_row_t directed_rows [N_DIRECTED] = '{
        '{ROW_SYM, REG_NUM_ROWS, 8'h00, 1'b1, 7'd0},   // 1x1 after reset
        '{ROW_SYM, REG_NUM_ROWS, 8'hFF, 1'b1, 7'd0},
        '{ROW_CFG, REG_NUM_COLS, 8'd2,  1'b0, 7'd0},
        '{ROW_SYM, REG_NUM_ROWS, 8'hFF, 1'b0, 7'd0},
        '{ROW_SYM, REG_NUM_ROWS, 8'h00, 1'b1, 7'd1},   // descending pair
        '{ROW_SYM, REG_NUM_ROWS, 8'h00, 1'b0, 7'd0},
        '{ROW_SYM, REG_NUM_ROWS, 8'hFF, 1'b1, 7'd0},   // ascending pair
        '{ROW_CFG, REG_NUM_ROWS, 8'd0,  1'b0, 7'd0},   // zero acts as one
        '{ROW_CFG, REG_NUM_COLS, 8'd3,  1'b0, 7'd0},
        '{ROW_SYM, REG_NUM_ROWS, 8'h05, 1'b0, 7'd0},
        '{ROW_SYM, REG_NUM_ROWS, 8'h05, 1'b0, 7'd0},
        '{ROW_SYM, REG_NUM_ROWS, 8'h05, 1'b1, 7'd0},   // equal values are in order
        '{ROW_CFG, REG_NUM_ROWS, 8'd2,  1'b0, 7'd0},
        '{ROW_CFG, REG_NUM_COLS, 8'd2,  1'b0, 7'd0},
        '{ROW_SYM, REG_NUM_ROWS, 8'h01, 1'b0, 7'd0},
        '{ROW_SYM, REG_NUM_ROWS, 8'h02, 1'b0, 7'd0},
        '{ROW_SYM, REG_NUM_ROWS, 8'h02, 1'b0, 7'd0},
        '{ROW_SYM, REG_NUM_ROWS, 8'h01, 1'b1, 7'd1},   // rows disagree
        '{ROW_SYM, REG_NUM_ROWS, 8'h09, 1'b0, 7'd0},   // partial load
        '{ROW_CFG, REG_NUM_COLS, 8'd2,  1'b0, 7'd0},   // restarts the load
        '{ROW_SYM, REG_NUM_ROWS, 8'h00, 1'b0, 7'd0},
        '{ROW_SYM, REG_NUM_ROWS, 8'h01, 1'b0, 7'd0},
        '{ROW_SYM, REG_NUM_ROWS, 8'h00, 1'b0, 7'd0},
        '{ROW_SYM, REG_NUM_ROWS, 8'h01, 1'b1, 7'd0},
        '{ROW_SYM, REG_NUM_ROWS, 8'h03, 1'b0, 7'd0},
        '{ROW_SYM, REG_NUM_ROWS, 8'h04, 1'b0, 7'd0},
        '{ROW_CFG, REG_SPARE_3,  8'hFF, 1'b0, 7'd0},   // ignored mid-load
        '{ROW_CFG, REG_SPARE_2,  8'h00, 1'b0, 7'd0},
        '{ROW_SYM, REG_NUM_ROWS, 8'h02, 1'b0, 7'd0},
        '{ROW_SYM, REG_NUM_ROWS, 8'h01, 1'b0, 7'd0}
    };

    column_chain_deletion_count #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 clk = ~clk;

    task automatic report_mismatch(string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatches++;
    endtask

    function automatic int unsigned clamp_dim(logic [DIMW-1:0] v, int unsigned lim);
        if (v == 0)
            return 1;
        if (v > lim)
            return lim;
        return v;
    endfunction

    // Longest chain of columns that are ordered in every row, by the
    // quadratic DP; the answer is the number of columns left out.
    function automatic logic [DELW-1:0] min_deletions();
        int unsigned run_len [MAX_COLS];
        int unsigned best;
        bit          ordered;
        best = 0;
        for (int i = 0; i < cols_now; i++)
        begin
            run_len[i] = 1;
            for (int j = 0; j < i; j++)
            begin
                if (run_len[j] + 1 > run_len[i])
                begin
                    ordered = 1'b1;
                    for (int r = 0; r < rows_now && ordered; r++)
                        if (grid_img[r*cols_now + j] > grid_img[r*cols_now + i])
                            ordered = 1'b0;
                    if (ordered)
                        run_len[i] = run_len[j] + 1;
                end
            end
            if (run_len[i] > best)
                best = run_len[i];
        end
        return DELW'(cols_now - best);
    endfunction

    task automatic absorb_symbol(logic [SYMW-1:0] sym, bit pinned, logic [DELW-1:0] pinned_val);
        int unsigned     total;
        logic [DELW-1:0] due;
        total = rows_now * cols_now;
        if (fill_pos >= total)
            fill_pos = 0;
        grid_img[fill_pos] = sym;
        fill_pos++;
        if (fill_pos == total)
        begin
            fill_pos = 0;
            due = pinned ? pinned_val : min_deletions();
            owed_deletions = {owed_deletions, due};
        end
    endtask

    task automatic settle();
        while (owed_deletions.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register writes only go in while nothing is outstanding.
    task automatic write_reg(logic [CFG_AW-1:0] idx, logic [DIMW-1:0] val);
        s_tvalid <= 1'b0;
        settle();
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge clk);
        if (idx == REG_NUM_ROWS)
        begin
            rows_now = clamp_dim(val, MAX_ROWS);
            fill_pos = 0;
        end
        else if (idx == REG_NUM_COLS)
        begin
            cols_now = clamp_dim(val, MAX_COLS);
            fill_pos = 0;
        end
        cfg_we <= 1'b0;
    endtask

    task automatic send_symbol(logic [SYMW-1:0] sym, bit eager, bit pinned = 1'b0,
                               logic [DELW-1:0] pinned_val = '0);
        int unsigned gap;
        gap = eager ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sym;
        do
            @(posedge clk);
        while (!s_tready);
        absorb_symbol(sym, pinned, pinned_val);
        items_sent++;
    endtask

    task automatic send_grid(int unsigned rows, int unsigned cols, fill_t fill, bit eager);
        int unsigned     acc;
        int unsigned     spare_at;
        logic [SYMW-1:0] sym;
        acc      = 0;
        spare_at = ($urandom_range(0, 7) == 0) ? $urandom_range(1, rows * cols) : 0;
        for (int pos = 0; pos < rows * cols; pos++)
        begin
            if (pos != 0 && pos == spare_at)
                write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                          DIMW'($urandom_range(0, 255)));
            case (fill)
                FILL_RANDOM: sym = SYMW'($urandom_range(0, 255));
                FILL_NARROW: sym = SYMW'($urandom_range(0, 3));
                FILL_RISING:
                begin
                    // Rows mostly climb, with an occasional wild value.
                    if (pos % cols == 0)
                        acc = $urandom_range(0, 63);
                    acc = acc + $urandom_range(0, 8);
                    if (acc > 255)
                        acc = 255;
                    sym = ($urandom_range(0, 4) == 0) ? SYMW'($urandom_range(0, 255))
                                                      : SYMW'(acc);
                end
                FILL_FLAT:   sym = 8'h5A;
                default:     sym = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            endcase
            send_symbol(sym, eager);
        end
    endtask

    initial
    begin : stimulus
        int unsigned r_val;
        int unsigned c_val;
        int unsigned cells;
        bit          eager;
        rst_n    = 1'b0;
        cfg_we   = 1'b0;
        cfg_addr = REG_NUM_ROWS;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        rows_now = 1;
        cols_now = 1;
        fill_pos = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < N_DIRECTED; k++)
        begin
            if (directed_rows[k].kind == ROW_CFG)
                write_reg(directed_rows[k].addr, directed_rows[k].value);
            else
                send_symbol(directed_rows[k].value, 1'b0, directed_rows[k].pinned,
                            directed_rows[k].deletions);
        end

        // Largest shapes: one tall column, then one long row both ways.
        write_reg(REG_NUM_ROWS, 8'd200);
        write_reg(REG_NUM_COLS, 8'd1);
        for (int k = 0; k < MAX_ROWS; k++)
            send_symbol(SYMW'($urandom_range(0, 255)), 1'b1);
        write_reg(REG_NUM_ROWS, 8'd1);
        write_reg(REG_NUM_COLS, 8'd255);
        for (int k = 0; k < MAX_COLS; k++)
            send_symbol(SYMW'(255 - k), 1'($urandom_range(0, 1)));
        write_reg(REG_NUM_COLS, 8'd128);
        for (int k = 0; k < MAX_COLS; k++)
            send_symbol(SYMW'(2 * k), 1'($urandom_range(0, 1)));

        // Back-to-back small grids while the output side holds off.
        write_reg(REG_NUM_ROWS, 8'd2);
        write_reg(REG_NUM_COLS, 8'd3);
        squeeze_req = 1'b1;
        repeat (6) send_grid(2, 3, fill_t'($urandom_range(0, 4)), 1'b1);

        while (items_sent < ITEM_TARGET)
        begin
            eager = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 11) == 0)
            begin
                r_val = $urandom_range(1, 16);
                c_val = $urandom_range(1, 24);
            end
            else
            begin
                r_val = $urandom_range(0, 4);
                c_val = $urandom_range(0, 8);
            end
            if ($urandom_range(0, 1))
            begin
                write_reg(REG_NUM_ROWS, DIMW'(r_val));
                write_reg(REG_NUM_COLS, DIMW'(c_val));
            end
            else
            begin
                write_reg(REG_NUM_COLS, DIMW'(c_val));
                write_reg(REG_NUM_ROWS, DIMW'(r_val));
            end
            r_val = clamp_dim(DIMW'(r_val), MAX_ROWS);
            c_val = clamp_dim(DIMW'(c_val), MAX_COLS);
            repeat ($urandom_range(1, 6))
                send_grid(r_val, c_val, fill_t'($urandom_range(0, 4)), eager);
            // Sometimes leave a grid half loaded for the next write to drop.
            cells = r_val * c_val;
            if (cells > 1 && $urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, cells - 1))
                    send_symbol(SYMW'($urandom_range(0, 255)), eager);
        end

        s_tvalid <= 1'b0;
        while (owed_deletions.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("column_chain_deletion_count_tb passed");
        else
            $display("column_chain_deletion_count_tb failed");
        $finish;
    end

    initial
    begin : result_sink
        int unsigned     stall;
        int unsigned     got;
        logic [DELW-1:0] want;
        m_tready = 1'b0;
        got      = 0;
        @(posedge rst_n);
        forever
        begin
            if (squeeze_req)
            begin
                squeeze_req = 1'b0;
                stall = SQUEEZE_CYCLES;
            end
            else if ((got / 16) % 3 == 2)
                stall = 0;
            else
                stall = $urandom_range(0, 13);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            got++;
            if (owed_deletions.size() == 0)
                report_mismatch($sformatf("deletions beat %0d with no grid outstanding",
                                          m_tdata[DELW-1:0]));
            else
            begin
                want = owed_deletions.pop_front();
                if (m_tdata[DELW-1:0] !== want)
                    report_mismatch($sformatf("deletions %0d, predicted %0d",
                                              m_tdata[DELW-1:0], want));
            end
        end
    end

    initial
    begin : watchdog
        #40_000_000;
        $display("column_chain_deletion_count_tb failed");
        $finish;
    end

endmodule
